[sv/qlt_pkg.sv]
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types and character constants for the quoted line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qlt_pkg;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // result queue: room for two results per accepted byte plus slack
    localparam int QLT_FIFO_DEPTH = 4;
    localparam int QLT_PTR_W      = $clog2(QLT_FIFO_DEPTH);
    localparam int QLT_CNT_W      = $clog2(QLT_FIFO_DEPTH + 1);

    typedef struct packed {
        logic in_quotes;
        logic escape_next;
        logic in_comment;
        logic slash_held;
        logic token_open;
    } qlt_state_t;

    typedef struct packed {
        logic       last_of_run;
        logic       open_quote_error;
        logic       line_done;
        logic       token_done;
        logic       byte_valid;
        logic [7:0] token_byte;
    } qlt_result_t;

endpackage

`default_nettype wire

[sv/qlt_core.sv]
// ----------------------------------------------------------------------------
// qlt_core
// Per-byte tokenizer step: next state and up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module qlt_core (
    input  wire logic [7:0]          text_byte,
    input  wire logic                end_of_line,
    input  wire qlt_pkg::qlt_state_t state_cur,
    output qlt_pkg::qlt_state_t      state_nxt,
    output logic [1:0]               res_count,
    output qlt_pkg::qlt_result_t     res0,
    output qlt_pkg::qlt_result_t     res1
);

    qlt_pkg::qlt_result_t slash_res;
    qlt_pkg::qlt_result_t h_res;
    qlt_pkg::qlt_result_t line_res;
    logic                 h_has;
    logic                 is_space;
    logic                 pre_slash;
    logic                 open_in;
    qlt_pkg::qlt_state_t  hs;

    assign is_space = ((text_byte >= qlt_pkg::CH_TAB) && (text_byte <= qlt_pkg::CH_CR))
                    || (text_byte == qlt_pkg::CH_SPACE);

    always_comb
    begin
        slash_res            = '0;
        slash_res.token_byte = qlt_pkg::CH_SLASH;
        slash_res.byte_valid = 1'b1;
    end

    // held slash followed by something other than a second slash
    assign pre_slash = state_cur.slash_held && (text_byte != qlt_pkg::CH_SLASH);
    assign open_in   = state_cur.token_open | state_cur.slash_held;

    // ordinary byte handling
    always_comb
    begin
        hs            = state_cur;
        hs.slash_held = 1'b0;
        hs.token_open = open_in;
        h_res         = '0;
        h_has         = 1'b0;
        if (!state_cur.in_quotes && text_byte == qlt_pkg::CH_HASH)
        begin
            hs.in_comment = 1'b1;
        end
        else if (!state_cur.in_quotes && text_byte == qlt_pkg::CH_SLASH)
        begin
            hs.slash_held = 1'b1;
        end
        else if (state_cur.escape_next)
        begin
            hs.escape_next   = 1'b0;
            h_res.token_byte = text_byte;
            h_res.byte_valid = 1'b1;
            h_has            = 1'b1;
            hs.token_open    = 1'b1;
        end
        else if (state_cur.in_quotes && text_byte == qlt_pkg::CH_BSLASH)
        begin
            hs.escape_next = 1'b1;
        end
        else if (text_byte == qlt_pkg::CH_DQUOTE)
        begin
            hs.in_quotes = ~state_cur.in_quotes;
        end
        else if (!state_cur.in_quotes && is_space)
        begin
            h_res.token_done = open_in;
            h_has            = open_in;
            hs.token_open    = 1'b0;
        end
        else
        begin
            h_res.token_byte = text_byte;
            h_res.byte_valid = 1'b1;
            h_has            = 1'b1;
            hs.token_open    = 1'b1;
        end
    end

    always_comb
    begin
        line_res                  = '0;
        line_res.line_done        = 1'b1;
        line_res.token_done       = open_in;
        line_res.open_quote_error = state_cur.in_quotes;
        line_res.last_of_run      = 1'b1;
    end

    always_comb
    begin
        state_nxt = state_cur;
        res_count = 2'd0;
        res0      = '0;
        res1      = '0;
        if (end_of_line)
        begin
            state_nxt = '0;
            if (state_cur.slash_held)
            begin
                res0      = slash_res;
                res1      = line_res;
                res_count = 2'd2;
            end
            else
            begin
                res0      = line_res;
                res_count = 2'd1;
            end
        end
        else if (state_cur.in_comment)
        begin
            state_nxt = state_cur;
        end
        else if (state_cur.slash_held && !pre_slash)
        begin
            // second slash: comment to line end
            state_nxt            = state_cur;
            state_nxt.slash_held = 1'b0;
            state_nxt.in_comment = 1'b1;
        end
        else if (pre_slash)
        begin
            state_nxt = hs;
            res0      = slash_res;
            if (h_has)
            begin
                res1             = h_res;
                res1.last_of_run = 1'b1;
                res_count        = 2'd2;
            end
            else
            begin
                res0.last_of_run = 1'b1;
                res_count        = 2'd1;
            end
        end
        else
        begin
            state_nxt        = hs;
            res0             = h_res;
            res0.last_of_run = 1'b1;
            res_count        = {1'b0, h_has};
        end
    end

endmodule

`default_nettype wire

[sv/qlt_out_fifo.sv]
// ----------------------------------------------------------------------------
// qlt_out_fifo
// Small result queue: pushes up to two results a cycle, pops at most one.
// ----------------------------------------------------------------------------
`default_nettype none

module qlt_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           push_count,
    input  wire qlt_pkg::qlt_result_t push0,
    input  wire qlt_pkg::qlt_result_t push1,
    output logic                      room2,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output qlt_pkg::qlt_result_t      out_res
);

    qlt_pkg::qlt_result_t              mem_reg [qlt_pkg::QLT_FIFO_DEPTH];
    logic [qlt_pkg::QLT_PTR_W-1:0]     head_reg, head_next;
    logic [qlt_pkg::QLT_PTR_W-1:0]     tail_reg, tail_next;
    logic [qlt_pkg::QLT_CNT_W-1:0]     count_reg, count_next;
    logic [qlt_pkg::QLT_PTR_W-1:0]     tail_plus1;
    logic                              pop;

    assign out_valid  = (count_reg != '0);
    assign out_res    = mem_reg[head_reg];
    assign pop        = out_valid & out_ready;
    assign room2      = (count_reg <= qlt_pkg::QLT_CNT_W'(qlt_pkg::QLT_FIFO_DEPTH - 2));
    assign tail_plus1 = tail_reg + qlt_pkg::QLT_PTR_W'(1);

    always_comb
    begin
        head_next  = head_reg + qlt_pkg::QLT_PTR_W'(pop);
        tail_next  = tail_reg + qlt_pkg::QLT_PTR_W'(push_count);
        count_next = count_reg + qlt_pkg::QLT_CNT_W'(push_count)
                   - qlt_pkg::QLT_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[tail_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[tail_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/quoted_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// quoted_line_tokenizer
// Shell-style tokenizer with quotes, escapes and line comments, one byte
// per transaction in, token bytes and token/line marks out.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata           | tuser                           | tlast
//  --------+-----+-----------------+---------------------------------+------------
//  s_axis  | in  | [7:0] text_byte | -                               | end_of_line
//  m_axis  | out | [7:0] token_byte| [0] byte_valid [1] token_done   | last_of_run
//          |     |                 | [2] line_done [3] open_quote_err|
//
//  One input transaction per cycle while s_tready is high. Each byte is decoded
//  in the cycle it is accepted: tokenizer state updates at that edge, and its
//  0..2 results are written to a 4-entry result queue and shown on m_axis
//  behind any results already queued. s_tready is high while at most two
//  results are queued, so a stalled consumer, or a run of two-result bytes,
//  backs up into s_axis. Reset clears tokenizer state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_line_tokenizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // end_of_line
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] token_byte
    output logic [3:0]      m_tuser,   // [0] byte_valid [1] token_done
                                       // [2] line_done [3] open_quote_error
    output logic            m_tlast    // last_of_run
);

    qlt_pkg::qlt_state_t  state_reg, state_next;
    qlt_pkg::qlt_state_t  step_state;
    qlt_pkg::qlt_result_t res0, res1, out_res;
    logic [1:0]           res_count;
    logic [1:0]           push_count;
    logic                 room2;
    logic                 accept;

    assign s_tready = room2;
    assign accept   = s_tvalid & s_tready;

    // decode of the byte at the input port against the current state
    qlt_core u_core (
        .text_byte   (s_tdata),
        .end_of_line (s_tlast),
        .state_cur   (state_reg),
        .state_nxt   (step_state),
        .res_count   (res_count),
        .res0        (res0),
        .res1        (res1)
    );

    assign state_next = accept ? step_state : state_reg;
    assign push_count = accept ? res_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result queue decouples the consumer from the byte stream
    qlt_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room2      (room2),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = out_res.token_byte;
    assign m_tuser = {out_res.open_quote_error, out_res.line_done,
                      out_res.token_done, out_res.byte_valid};
    assign m_tlast = out_res.last_of_run;

endmodule

`default_nettype wire
